// ===== src/second_tick_supervisor_defines.svh =====
// ----------------------------------------------------------------------------
// Second tick supervisor: shared assertion macros
// Concurrent checks sampled on clk and masked while rst is high.
// ----------------------------------------------------------------------------
`ifndef SECOND_TICK_SUPERVISOR_DEFINES_SVH
`define SECOND_TICK_SUPERVISOR_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define STS_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define STS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Widths, reset values, register indexes and shared types of the second tick
// supervisor.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Tick counter width
  localparam int TICK_WIDTH = 32;
  localparam int STEP_W     = $clog2(TICK_WIDTH);

  // Field widths
  localparam int RSSI_W   = 8;
  localparam int MV_W     = 13;
  localparam int ADDR_W   = 8;
  localparam int WORD_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Remainder lanes of the modulo unit, one per register-set divisor
  localparam int NUM_LANES   = 2;
  localparam int LANE_CYCLE  = 0;
  localparam int LANE_CFG    = 1;

  // Fixed divisors
  localparam logic [WORD_W-1:0] HOUR_TICKS   = 16'd3600;
  localparam logic [WORD_W-1:0] SAMPLE_TICKS = 16'd17;
  localparam logic [WORD_W-1:0] POWER_TICKS  = 16'd61;
  localparam logic [WORD_W-1:0] CFG_BASE     = 16'd123;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RSSI_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_OFF_MV  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_ON_MV   = 3'd5;

  // Configuration reset values
  localparam logic [WORD_W-1:0]        CYCLE_PERIOD_RST = 16'd60;
  localparam logic [ADDR_W-1:0]        NODE_ADDRESS_RST = 8'd1;
  localparam logic [WORD_W-1:0]        LED_LIMIT_RST    = 16'd28800;
  localparam logic signed [RSSI_W-1:0] RSSI_LOW_RST     = -8'sd70;
  localparam logic [MV_W-1:0]          VOLT_OFF_MV_RST  = 13'd3600;
  localparam logic [MV_W-1:0]          VOLT_ON_MV_RST   = 13'd3800;

  typedef logic [WORD_W-1:0] lane_word_t;

  // One input item
  typedef struct packed {
    logic                     current_busy;
    logic                     efield_busy;
    logic                     starting;
    logic                     cycle_done;
    logic                     radio_idle;
    logic                     current_fault;
    logic                     efield_fault;
    logic signed [RSSI_W-1:0] rssi;
    logic [MV_W-1:0]          supply_mv;
  } item_t;

  // One result item
  typedef struct packed {
    logic watchdog_level;
    logic reset_request;
    logic cycle_event;
    logic report_send;
    logic config_send;
    logic radio_reinit;
    logic sample_event;
    logic led_level;
    logic fault_clear;
    logic radio_power;
    logic radio_init;
  } result_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

endpackage

// ===== src/sts_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_if
// Valid/ready channels of the second tick supervisor: tick items in, results
// out.
// ----------------------------------------------------------------------------
interface sts_in_if;
  logic                              valid;
  logic                              ready;
  logic                              current_busy;
  logic                              efield_busy;
  logic                              starting;
  logic                              cycle_done;
  logic                              radio_idle;
  logic                              current_fault;
  logic                              efield_fault;
  logic signed [sts_pkg::RSSI_W-1:0] rssi;
  logic [sts_pkg::MV_W-1:0]          supply_mv;

  modport source (output valid, current_busy, efield_busy, starting, cycle_done,
                  radio_idle, current_fault, efield_fault, rssi, supply_mv,
                  input ready);
  modport sink (input valid, current_busy, efield_busy, starting, cycle_done,
                radio_idle, current_fault, efield_fault, rssi, supply_mv,
                output ready);
endinterface

interface sts_out_if;
  logic valid;
  logic ready;
  logic watchdog_level;
  logic reset_request;
  logic cycle_event;
  logic report_send;
  logic config_send;
  logic radio_reinit;
  logic sample_event;
  logic led_level;
  logic fault_clear;
  logic radio_power;
  logic radio_init;

  modport source (output valid, watchdog_level, reset_request, cycle_event,
                  report_send, config_send, radio_reinit, sample_event,
                  led_level, fault_clear, radio_power, radio_init,
                  input ready);
  modport sink (input valid, watchdog_level, reset_request, cycle_event,
                report_send, config_send, radio_reinit, sample_event,
                led_level, fault_clear, radio_power, radio_init,
                output ready);
endinterface

// ===== src/sts_mod_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_mod_unit
// Bit-serial remainder unit: one dividend, several divisor lanes, one
// restoring step per cycle for all lanes while step is high.
// ----------------------------------------------------------------------------
module sts_mod_unit (
  input  logic                                   clk,
  input  logic                                   load,
  input  logic                                   step,
  input  logic [sts_pkg::TICK_WIDTH-1:0]         dividend,
  input  sts_pkg::lane_word_t [sts_pkg::NUM_LANES-1:0] divisors,
  output sts_pkg::lane_word_t [sts_pkg::NUM_LANES-1:0] rems
);

  logic [sts_pkg::TICK_WIDTH-1:0]                shift;
  sts_pkg::lane_word_t [sts_pkg::NUM_LANES-1:0]  rems_next;

  // Shift in the next dividend bit and subtract where the divisor fits
  always_comb begin
    logic [sts_pkg::WORD_W:0] trial;
    logic [sts_pkg::WORD_W:0] dvs;
    for (int i = 0; i < sts_pkg::NUM_LANES; i++) begin
      trial = {rems[i], shift[sts_pkg::TICK_WIDTH-1]};
      dvs   = {1'b0, divisors[i]};
      if (trial >= dvs) begin
        rems_next[i] = sts_pkg::WORD_W'(trial - dvs);
      end else begin
        rems_next[i] = trial[sts_pkg::WORD_W-1:0];
      end
    end
  end

  // Load the dividend, then advance one bit per step
  always_ff @(posedge clk) begin
    if (load) begin
      shift <= dividend;
      rems  <= '0;
    end else if (step) begin
      shift <= shift << 1;
      rems  <= rems_next;
    end
  end

endmodule

// ===== src/sts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_datapath
// Configuration registers, supervisor state, remainder unit and the result
// register of the second tick supervisor.
// ----------------------------------------------------------------------------
module sts_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  sts_pkg::cmd_t                    cmd,
  input  sts_pkg::item_t                   item,
  input  logic                             cfg_we,
  input  logic [sts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sts_pkg::CFG_W-1:0]        cfg_data,
  output sts_pkg::result_t                 result
);

  localparam logic [7:0] BUSY_LIMIT   = 8'd250;
  localparam logic [7:0] BUSY_MAX     = 8'd255;
  localparam logic [7:0] WEAK_ON      = 8'd61;
  localparam logic [7:0] WEAK_MAX     = 8'd75;
  localparam logic [7:0] WEAK_OFF_LO  = 8'd10;
  localparam logic [7:0] WEAK_OFF_HI  = 8'd59;
  localparam logic [7:0] WEAK_RESTART = 8'd1;
  localparam int         TW           = sts_pkg::TICK_WIDTH;

  // Configuration
  logic [sts_pkg::WORD_W-1:0]        cycle_period;
  logic [sts_pkg::ADDR_W-1:0]        node_address;
  logic [sts_pkg::WORD_W-1:0]        led_limit;
  logic signed [sts_pkg::RSSI_W-1:0] rssi_low;
  logic [sts_pkg::MV_W-1:0]          volt_off_mv;
  logic [sts_pkg::MV_W-1:0]          volt_on_mv;

  // Supervisor state
  logic [TW-1:0]              tick_count;
  logic [TW-1:0]              report_tick;
  logic [7:0]                 busy_ticks;
  logic [sts_pkg::WORD_W-1:0] blink_ticks;
  logic [7:0]                 weak_checks;
  logic                       cycle_busy;
  logic                       led_state;
  logic                       power_state;
  logic                       watchdog_state;

  // Tick residues for the fixed periods
  logic [sts_pkg::WORD_W-1:0] hour_res;
  logic [sts_pkg::WORD_W-1:0] sample_res;
  logic [sts_pkg::WORD_W-1:0] power_res;
  logic                       tick_wraps;

  // Held item and next values
  sts_pkg::item_t             item_hold;
  logic [TW-1:0]              report_tick_next;
  logic [7:0]                 busy_ticks_next;
  logic [sts_pkg::WORD_W-1:0] blink_ticks_next;
  logic [7:0]                 weak_checks_next;
  logic                       cycle_busy_next;
  logic                       led_state_next;
  logic                       power_state_next;
  sts_pkg::result_t           result_next;

  sts_pkg::lane_word_t [sts_pkg::NUM_LANES-1:0] divisors;
  sts_pkg::lane_word_t [sts_pkg::NUM_LANES-1:0] rems;

  assign tick_wraps = &tick_count;

  // Divisor lanes
  always_comb begin
    divisors                       = '0;
    divisors[sts_pkg::LANE_CYCLE]  = cycle_period;
    divisors[sts_pkg::LANE_CFG]    = sts_pkg::CFG_BASE +
                                     sts_pkg::WORD_W'({node_address, 1'b0});
  end

  sts_mod_unit u_mod (
    .clk      (clk),
    .load     (cmd.load),
    .step     (cmd.step),
    .dividend (tick_count + TW'(1)),
    .divisors (divisors),
    .rems     (rems)
  );

  // Work out the tick from the held item, the state and the remainders
  always_comb begin
    logic busy;
    logic fault;
    logic period_multiple;
    logic tick_nonzero;
    busy            = item_hold.current_busy | item_hold.efield_busy | item_hold.starting;
    fault           = item_hold.current_fault | item_hold.efield_fault;
    tick_nonzero    = (tick_count != '0);
    period_multiple = (cycle_period != '0) && (rems[sts_pkg::LANE_CYCLE] == '0);

    report_tick_next = report_tick;
    busy_ticks_next  = busy_ticks;
    blink_ticks_next = blink_ticks;
    weak_checks_next = weak_checks;
    cycle_busy_next  = cycle_busy & ~item_hold.cycle_done;
    led_state_next   = led_state;
    power_state_next = power_state;
    result_next      = '0;
    result_next.watchdog_level = ~watchdog_state;

    if (busy) begin
      // Count toward a forced reset, saturating
      if (busy_ticks < BUSY_MAX) begin
        busy_ticks_next = busy_ticks + 8'd1;
      end
      result_next.reset_request = (busy_ticks_next > BUSY_LIMIT);
    end else begin
      busy_ticks_next = '0;

      // Cycle event and staggered report slot
      if (period_multiple && tick_nonzero) begin
        cycle_busy_next         = 1'b1;
        result_next.cycle_event = 1'b1;
        case (node_address)
          8'd1:    report_tick_next = tick_count + TW'(3);
          8'd2:    report_tick_next = tick_count + TW'(10);
          8'd3:    report_tick_next = tick_count + TW'(17);
          default: report_tick_next = '0;
        endcase
      end

      result_next.report_send  = (tick_count == report_tick_next);
      result_next.config_send  = (rems[sts_pkg::LANE_CFG] == '0) && item_hold.radio_idle &&
                                 (tick_count != report_tick_next);
      result_next.radio_reinit = (hour_res == '0) && tick_nonzero &&
                                 (tick_count != report_tick_next);
      result_next.sample_event = !cycle_busy_next && (sample_res == '0) &&
                                 tick_nonzero && !period_multiple && item_hold.radio_idle;

      // Fault LED blink with timeout
      if (fault && (blink_ticks < led_limit)) begin
        led_state_next   = ~led_state;
        blink_ticks_next = blink_ticks + sts_pkg::WORD_W'(1);
      end else if (!fault && (blink_ticks != '0)) begin
        led_state_next   = 1'b0;
        blink_ticks_next = '0;
      end else if (blink_ticks >= led_limit) begin
        led_state_next          = 1'b0;
        result_next.fault_clear = 1'b1;
        blink_ticks_next        = '0;
      end

      // Weak-signal power cycling and supply cutoff
      if (power_res == '0) begin
        if (item_hold.rssi < rssi_low) begin
          weak_checks_next = weak_checks + 8'd1;
        end else begin
          weak_checks_next = '0;
        end

        if ((weak_checks_next > WEAK_ON - 8'd1) && (weak_checks_next <= WEAK_MAX)) begin
          if (weak_checks_next == WEAK_ON) begin
            power_state_next       = 1'b1;
            result_next.radio_init = 1'b1;
          end
        end else if (weak_checks_next > WEAK_MAX) begin
          power_state_next = 1'b0;
          weak_checks_next = WEAK_RESTART;
        end else if ((weak_checks_next > WEAK_OFF_LO) && (weak_checks_next < WEAK_OFF_HI)) begin
          power_state_next = 1'b0;
        end

        if (item_hold.supply_mv < volt_off_mv) begin
          power_state_next = 1'b0;
        end else if (item_hold.supply_mv < volt_on_mv) begin
          power_state_next = 1'b1;
        end
      end
    end

    result_next.led_level   = led_state_next;
    result_next.radio_power = power_state_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_period <= sts_pkg::CYCLE_PERIOD_RST;
      node_address <= sts_pkg::NODE_ADDRESS_RST;
      led_limit    <= sts_pkg::LED_LIMIT_RST;
      rssi_low     <= sts_pkg::RSSI_LOW_RST;
      volt_off_mv  <= sts_pkg::VOLT_OFF_MV_RST;
      volt_on_mv   <= sts_pkg::VOLT_ON_MV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sts_pkg::REG_CYCLE_PERIOD: cycle_period <= cfg_data;
        sts_pkg::REG_NODE_ADDRESS: node_address <= cfg_data[sts_pkg::ADDR_W-1:0];
        sts_pkg::REG_LED_LIMIT:    led_limit    <= cfg_data;
        sts_pkg::REG_RSSI_LOW:     rssi_low     <= cfg_data[sts_pkg::RSSI_W-1:0];
        sts_pkg::REG_VOLT_OFF_MV:  volt_off_mv  <= cfg_data[sts_pkg::MV_W-1:0];
        sts_pkg::REG_VOLT_ON_MV:   volt_on_mv   <= cfg_data[sts_pkg::MV_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the tick and its residues on load, commit the rest at the end;
  // a tick that wraps to zero restarts every residue
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      hour_res       <= '0;
      sample_res     <= '0;
      power_res      <= '0;
      report_tick    <= '0;
      busy_ticks     <= '0;
      blink_ticks    <= '0;
      weak_checks    <= '0;
      cycle_busy     <= 1'b0;
      led_state      <= 1'b0;
      power_state    <= 1'b1;
      watchdog_state <= 1'b0;
    end else if (cmd.load) begin
      tick_count <= tick_count + TW'(1);
      hour_res   <= (tick_wraps || (hour_res == sts_pkg::HOUR_TICKS - sts_pkg::WORD_W'(1))) ?
                    '0 : hour_res + sts_pkg::WORD_W'(1);
      sample_res <= (tick_wraps ||
                     (sample_res == sts_pkg::SAMPLE_TICKS - sts_pkg::WORD_W'(1))) ?
                    '0 : sample_res + sts_pkg::WORD_W'(1);
      power_res  <= (tick_wraps || (power_res == sts_pkg::POWER_TICKS - sts_pkg::WORD_W'(1))) ?
                    '0 : power_res + sts_pkg::WORD_W'(1);
    end else if (cmd.commit) begin
      report_tick    <= report_tick_next;
      busy_ticks     <= busy_ticks_next;
      blink_ticks    <= blink_ticks_next;
      weak_checks    <= weak_checks_next;
      cycle_busy     <= cycle_busy_next;
      led_state      <= led_state_next;
      power_state    <= power_state_next;
      watchdog_state <= ~watchdog_state;
    end
  end

  // Hold the item and the result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_hold <= item;
    end
    if (cmd.commit) begin
      result <= result_next;
    end
  end

endmodule

// ===== src/sts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_ctrl
// Controller of the second tick supervisor: accepts an item, runs the
// remainder unit for one step per dividend bit, then commits into the
// output register.
// ----------------------------------------------------------------------------
`include "second_tick_supervisor_defines.svh"

module sts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sts_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [sts_pkg::STEP_W-1:0] LAST_STEP =
    sts_pkg::STEP_W'(sts_pkg::TICK_WIDTH - 1);

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [sts_pkg::STEP_W-1:0]  step_cnt;
  logic                        in_fire;
  logic                        slot_free;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign slot_free = ~out_valid | out_ready;

  // Sequence the item through load, steps and commit
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (step_cnt == LAST_STEP) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.step) begin
        step_cnt <= (step_cnt == LAST_STEP) ? '0 : step_cnt + sts_pkg::STEP_W'(1);
      end
      // Raise valid on commit, drop it once taken
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `STS_ASSERT_NEXT(a_fire_runs, in_fire, state == S_RUN, "accepted item did not start")
  `STS_ASSERT_SAME(a_commit_free, cmd.commit, !out_valid || out_ready,
                   "commit overwrote a waiting result")
  `STS_ASSERT_SAME(a_idle_count, state != S_RUN, step_cnt == '0,
                   "step counter not cleared outside the run")

endmodule

// ===== src/second_tick_supervisor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_tick_supervisor
// Once-per-second supervisor: watchdog feed, forced reset on long busy,
// periodic events, fault LED timeout and radio power management.
// ----------------------------------------------------------------------------
//   channel      dir   handshake     content
//   tick_in      in    valid/ready   status flags, rssi, supply millivolts
//   result_out   out   valid/ready   watchdog, events, LED and radio levels
//   cfg_*        in    write enable  six registers, index 0 to 5
//
// Each item is loaded, then takes one restoring step per tick bit in the
// shared remainder unit, then is committed.
// A new item is taken while the previous result waits in the output register;
// the commit holds until that register is free.
// Reset: synchronous; configuration returns to its defaults, radio powered.
// ----------------------------------------------------------------------------
module second_tick_supervisor (
  input  logic                          clk,
  input  logic                          rst,
  sts_in_if.sink                        tick_in,
  sts_out_if.source                     result_out,
  input  logic                          cfg_we,
  input  logic [sts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sts_pkg::CFG_W-1:0]     cfg_data
);

  sts_pkg::cmd_t    cmd;
  sts_pkg::item_t   item;
  sts_pkg::result_t result;

  // Pack the input item
  assign item.current_busy  = tick_in.current_busy;
  assign item.efield_busy   = tick_in.efield_busy;
  assign item.starting      = tick_in.starting;
  assign item.cycle_done    = tick_in.cycle_done;
  assign item.radio_idle    = tick_in.radio_idle;
  assign item.current_fault = tick_in.current_fault;
  assign item.efield_fault  = tick_in.efield_fault;
  assign item.rssi          = tick_in.rssi;
  assign item.supply_mv     = tick_in.supply_mv;

  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick_in.valid),
    .in_ready  (tick_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .cmd       (cmd)
  );

  sts_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  // Drive the result fields
  assign result_out.watchdog_level = result.watchdog_level;
  assign result_out.reset_request  = result.reset_request;
  assign result_out.cycle_event    = result.cycle_event;
  assign result_out.report_send    = result.report_send;
  assign result_out.config_send    = result.config_send;
  assign result_out.radio_reinit   = result.radio_reinit;
  assign result_out.sample_event   = result.sample_event;
  assign result_out.led_level      = result.led_level;
  assign result_out.fault_clear    = result.fault_clear;
  assign result_out.radio_power    = result.radio_power;
  assign result_out.radio_init     = result.radio_init;

endmodule
